// File: design/tra_pkg.sv
// Shared types and codes for the temp register allocator.
`timescale 1ns / 1ps

package tra_pkg;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_REUSED    = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [5:0] granted_slot;
    status_t    status;
    logic [6:0] high_water;
    logic [6:0] in_use;
  } rsp_t;

endpackage

// File: design/tra_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps

module tra_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/temp_register_allocator.sv
// Top level: slot pool allocator with LIFO free stack and high-water mark.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  req     | in  | req_valid/req_stall | cmd, slot_index
//  rsp     | out | rsp_valid/rsp_stall | granted_slot, status, high_water, in_use
//
// Per item, the accept edge issues the busy-map and stack reads; EXEC then updates
// the busy map and, on a release, the stack, and loads the result register.
// After reset the busy map is swept to zero, one entry a cycle, over all POOL_SLOTS
// entries; req_stall stays high meanwhile.
// A new item is taken while the previous result is being taken; a stalled
// result holds the block in idle.
`timescale 1ns / 1ps

module temp_register_allocator #(
  parameter int POOL_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tra_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tra_pkg::rsp_t rsp
);

  import tra_pkg::*;

  localparam int BW = $clog2(POOL_SLOTS);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  fsm_t          state, state_next;
  logic [BW-1:0] clr_addr;
  logic [CW-1:0] freed_count, freed_count_next;
  logic [CW-1:0] next_fresh, next_fresh_next;
  cmd_t          cur_cmd;
  logic [5:0]    cur_idx;
  logic          cur_ok;

  logic          accept;
  logic [CW-1:0] fc_dec;
  logic [XW-1:0] grant_x, nf_x, use_x;
  status_t       status;

  logic          busy_we, busy_wdata, busy_rdata;
  logic [BW-1:0] busy_waddr, busy_raddr;
  logic          stack_we;
  logic [BW-1:0] stack_waddr, stack_raddr;
  logic [5:0]    stack_wdata, stack_rdata;

  assign req_stall = (state != FSM_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  assign fc_dec      = freed_count - 1'b1;
  assign busy_raddr  = BW'(XW'(req.slot_index));
  assign stack_raddr = fc_dec[BW-1:0];

  tra_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_busy (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (busy_raddr),
    .rdata (busy_rdata)
  );

  tra_ram #(.WIDTH(6), .DEPTH(POOL_SLOTS)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      FSM_CLEAR: begin
        if (clr_addr == BW'(POOL_SLOTS - 1)) begin
          state_next = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: state_next = FSM_IDLE;
      default:  state_next = FSM_CLEAR;
    endcase
  end

  always_comb begin
    busy_we          = 1'b0;
    busy_waddr       = clr_addr;
    busy_wdata       = 1'b0;
    stack_we         = 1'b0;
    stack_waddr      = freed_count[BW-1:0];
    stack_wdata      = cur_idx;
    freed_count_next = freed_count;
    next_fresh_next  = next_fresh;
    grant_x          = '0;
    status           = ST_IGNORED;
    case (state)
      FSM_CLEAR: busy_we = 1'b1;
      FSM_EXEC: begin
        if (cur_cmd == CMD_ALLOC) begin
          if (freed_count != '0) begin
            grant_x          = XW'(stack_rdata);
            busy_we          = 1'b1;
            busy_waddr       = grant_x[BW-1:0];
            busy_wdata       = 1'b1;
            freed_count_next = fc_dec;
            status           = ST_REUSED;
          end else if (next_fresh < CW'(POOL_SLOTS)) begin
            grant_x         = XW'(next_fresh);
            busy_we         = 1'b1;
            busy_waddr      = grant_x[BW-1:0];
            busy_wdata      = 1'b1;
            next_fresh_next = next_fresh + 1'b1;
            status          = ST_NEW;
          end else begin
            status = ST_EXHAUSTED;
          end
        end else if (cur_ok && busy_rdata) begin
          busy_we    = 1'b1;
          busy_waddr = BW'(XW'(cur_idx));
          busy_wdata = 1'b0;
          if (freed_count < CW'(POOL_SLOTS)) begin
            stack_we         = 1'b1;
            freed_count_next = freed_count + 1'b1;
          end
          status = ST_RELEASED;
        end
      end
      default: ;
    endcase
  end

  assign nf_x  = XW'(next_fresh_next);
  assign use_x = XW'(next_fresh_next) - XW'(freed_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= FSM_CLEAR;
      clr_addr    <= '0;
      freed_count <= '0;
      next_fresh  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      freed_count <= freed_count_next;
      next_fresh  <= next_fresh_next;
      if (state == FSM_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == FSM_EXEC) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd <= req.cmd;
      cur_idx <= req.slot_index;
      cur_ok  <= XW'(req.slot_index) < XW'(POOL_SLOTS);
    end
    if (state == FSM_EXEC) begin
      rsp.granted_slot <= grant_x[5:0];
      rsp.status       <= status;
      rsp.high_water   <= nf_x[6:0];
      rsp.in_use       <= use_x[6:0];
    end
  end

endmodule
